// ===== src/nnt_pkg.sv =====
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types and constants for the nearest-neighbour tour orderer.
// ----------------------------------------------------------------------------
`default_nettype none

package nnt_pkg;

    localparam int ID_BITS        = 16;
    localparam int COORD_BITS     = 16;
    localparam int MAX_NODES_DEF  = 64;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int DIST_BITS      = SQ_BITS + 1;

    typedef struct packed {
        logic [ID_BITS-1:0]           node_id;
        logic signed [COORD_BITS-1:0] node_x;
        logic signed [COORD_BITS-1:0] node_y;
        logic                         is_last;
    } t_in_beat;

    typedef struct packed {
        logic [ID_BITS-1:0]           out_id;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         out_last;
        logic                         overflow;
    } t_out_beat;

    // one stored node
    typedef struct packed {
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_node;

    // queue control towards the cell chain
    typedef struct packed {
        logic pop;
        logic push;
    } t_q_ctl;

endpackage

`default_nettype wire

// ===== src/nnt_cell.sv =====
// ----------------------------------------------------------------------------
// nnt_cell
// One slot of the shifting node queue; takes its neighbour or the insert.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_cell #(
    parameter int K     = 0,
    parameter int LEN_W = 7
) (
    input  wire               i_clk,
    input  nnt_pkg::t_q_ctl   i_ctl,
    input  wire [LEN_W-1:0]   i_len,
    input  nnt_pkg::t_node    i_next,
    input  nnt_pkg::t_node    i_ins,
    output nnt_pkg::t_node    o_node
);
    import nnt_pkg::*;

    t_node r_node;
    t_node n_node;
    logic  w_wr;

    // tail slot: after a shift it sits one place lower
    always_comb begin
        if (i_ctl.pop) begin
            w_wr = i_ctl.push && (i_len == LEN_W'(K + 1));
        end else begin
            w_wr = i_ctl.push && (i_len == LEN_W'(K));
        end
        if (w_wr) begin
            n_node = i_ins;
        end else if (i_ctl.pop) begin
            n_node = i_next;
        end else begin
            n_node = r_node;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    assign o_node = r_node;

endmodule

`default_nettype wire

// ===== src/nnt_dist.sv =====
// ----------------------------------------------------------------------------
// nnt_dist
// Squared Euclidean distance: registered squares, then the sum with carry.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_dist (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  nnt_pkg::t_node                 i_a,
    input  nnt_pkg::t_node                 i_b,
    output wire [nnt_pkg::DIST_BITS-1:0]   o_dist
);
    import nnt_pkg::*;

    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS:0]        w_ax;
    logic [COORD_BITS:0]        w_ay;
    logic [SQ_BITS-1:0]         r_sx;
    logic [SQ_BITS-1:0]         r_sy;

    always_comb begin
        w_dx = {i_a.x[COORD_BITS-1], i_a.x} - {i_b.x[COORD_BITS-1], i_b.x};
        w_dy = {i_a.y[COORD_BITS-1], i_a.y} - {i_b.y[COORD_BITS-1], i_b.y};
        w_ax = w_dx[COORD_BITS] ? -w_dx : w_dx;
        w_ay = w_dy[COORD_BITS] ? -w_dy : w_dy;
    end

    // |d| < 2^COORD_BITS, so the top bit is always clear
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= w_ax[COORD_BITS-1:0] * w_ax[COORD_BITS-1:0];
            r_sy <= w_ay[COORD_BITS-1:0] * w_ay[COORD_BITS-1:0];
        end
    end

    assign o_dist = {1'b0, r_sx} + {1'b0, r_sy};

endmodule

`default_nettype wire

// ===== src/nearest_neighbor_tour_core.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_core
// Greedy nearest-neighbour tour orderer over a chain of node cells.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready, payload i_node): one beat per node, the
// final node carries is_last. Loading takes one beat per cycle. Up to
// MAX_NODES nodes are kept; further nodes of the list are dropped and every
// result beat of that list then shows overflow.
// After the last beat o_ready stays low while the list is ordered and sent.
// The first result (the first stored node) is on offer once S_ANCH has
// popped it after the last input beat. Each later position takes one pass
// over the unordered rest of the queue; each node compared is squared in
// S_MUL, then summed and compared in S_CMP, in the one shared distance unit.
// Output channel (o_valid / i_ready, payload o_result): results leave in
// tour order, out_last on the final one. A stall holds the beat in its
// register and the ordering pauses until it is taken.
// Reset (i_rst_n low, synchronous) empties the queue, clears the overflow
// flag and returns to loading; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_tour_core #(
    parameter int MAX_NODES = nnt_pkg::MAX_NODES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output wire                  o_ready,
    input  nnt_pkg::t_in_beat    i_node,
    output wire                  o_valid,
    input  wire                  i_ready,
    output nnt_pkg::t_out_beat   o_result
);
    import nnt_pkg::*;

    localparam int LEN_W = $clog2(MAX_NODES + 1);

    localparam logic [2:0] S_LOAD = 3'd0;  // taking beats
    localparam logic [2:0] S_ANCH = 3'd1;  // pop first node
    localparam logic [2:0] S_POPB = 3'd2;  // pop first candidate of a pass
    localparam logic [2:0] S_MUL  = 3'd3;  // squares
    localparam logic [2:0] S_CMP  = 3'd4;  // sum, compare, next candidate
    localparam logic [2:0] S_OUT  = 3'd5;  // result beat on offer

    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic             r_dropped, n_dropped;
    logic             r_last, n_last;
    logic             r_first, n_first;
    t_node            r_anchor, n_anchor;   // current tour node
    t_node            r_best, n_best;       // best successor so far
    t_node            r_cand, n_cand;       // node under test
    logic [DIST_BITS-1:0] r_dbest, n_dbest;

    t_q_ctl           w_ctl;
    t_node            w_ins;
    t_node            w_cell [MAX_NODES];
    logic [DIST_BITS-1:0] w_dist;
    logic             w_take;
    logic             w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && (r_state == S_LOAD);
    assign w_out_acc = i_ready && (r_state == S_OUT);
    assign w_take    = r_first || (w_dist < r_dbest);

    // queue of not yet placed nodes
    for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
        t_node w_next;
        if (k == MAX_NODES - 1) begin : g_end
            assign w_next = w_ins;
        end else begin : g_mid
            assign w_next = w_cell[k+1];
        end
        nnt_cell #(.K(k), .LEN_W(LEN_W)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_len  (r_len),
            .i_next (w_next),
            .i_ins  (w_ins),
            .o_node (w_cell[k])
        );
    end

    nnt_dist u_dist (
        .i_clk  (i_clk),
        .i_en   (r_state == S_MUL),
        .i_a    (r_anchor),
        .i_b    (r_cand),
        .o_dist (w_dist)
    );

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_rem     = r_rem;
        n_dropped = r_dropped;
        n_last    = r_last;
        n_first   = r_first;
        n_anchor  = r_anchor;
        n_best    = r_best;
        n_cand    = r_cand;
        n_dbest   = r_dbest;
        w_ctl     = '0;
        w_ins     = r_cand;

        unique case (r_state)
            S_LOAD: begin
                w_ins.id = i_node.node_id;
                w_ins.x  = i_node.node_x;
                w_ins.y  = i_node.node_y;
                if (w_in_acc) begin
                    if (r_len < LEN_W'(MAX_NODES)) begin
                        w_ctl.push = 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_node.is_last) begin
                        n_state = S_ANCH;
                    end
                end
            end
            S_ANCH: begin
                n_anchor  = w_cell[0];
                n_last    = (r_len == LEN_W'(1));
                w_ctl.pop = 1'b1;
                n_state   = S_OUT;
            end
            S_POPB: begin
                n_cand    = w_cell[0];
                n_first   = 1'b1;
                n_rem     = r_len - LEN_W'(1);
                w_ctl.pop = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // loser of each compare goes back to the tail, in the order it loses
                w_ins      = w_take ? r_best : r_cand;
                w_ctl.push = !r_first;
                if (w_take) begin
                    n_best  = r_cand;
                    n_dbest = w_dist;
                end
                if (r_rem != '0) begin
                    w_ctl.pop = 1'b1;
                    n_cand    = w_cell[0];
                    n_rem     = r_rem - LEN_W'(1);
                    n_first   = 1'b0;
                    n_state   = S_MUL;
                end else begin
                    n_anchor = w_take ? r_cand : r_best;
                    n_last   = r_first && (r_len == '0);
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_last) begin
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_state   = S_POPB;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        n_len = r_len + LEN_W'(w_ctl.push) - LEN_W'(w_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_len     <= '0;
            r_dropped <= 1'b0;
            r_last    <= 1'b0;
            r_first   <= 1'b0;
            r_rem     <= '0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_dropped <= n_dropped;
            r_last    <= n_last;
            r_first   <= n_first;
            r_rem     <= n_rem;
        end
        r_anchor <= n_anchor;
        r_best   <= n_best;
        r_cand   <= n_cand;
        r_dbest  <= n_dbest;
    end

    assign o_ready           = (r_state == S_LOAD);
    assign o_valid           = (r_state == S_OUT);
    assign o_result.out_id   = r_anchor.id;
    assign o_result.out_x    = r_anchor.x;
    assign o_result.out_y    = r_anchor.y;
    assign o_result.out_last = r_last;
    assign o_result.overflow = r_dropped;

    // never take a beat while a result is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("load and emit overlap");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_NODES)) else $error("queue length past capacity");

    // final beat of a tour leaves an empty queue and reopens loading
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_result.out_last) |=> (o_ready && r_len == '0))
        else $error("tour end with nodes left");

    // past the first candidate every pop is matched by a push
    a_pass_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_rem != '0 && !r_first)
        |=> (r_state == S_MUL && $stable(r_len)))
        else $error("queue length moved during a pass");

endmodule

`default_nettype wire

// ===== tb/tb_nearest_neighbor_tour_core.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_tour_core
// Self-checking bench for the nearest-neighbour tour orderer: node lists are
// loaded, the reordered tour beats are compared against a local greedy model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_nearest_neighbor_tour_core;
    import nnt_pkg::*;

    localparam int NODES     = MAX_NODES_DEF;
    localparam int N_DIRECT  = 14;
    localparam int RAND_GOAL = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_node;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_result;

    nearest_neighbor_tour_core #(.MAX_NODES(NODES)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_node   (i_node),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // tour model state: the list being collected and its overflow flag
    t_node     list_nodes[NODES];
    int        list_len;
    bit        list_dropped;
    t_out_beat tour_q[$];
    int        mismatches;
    int        beats_checked;
    int        tours_seen;
    int        nodes_sent;

    function automatic logic [DIST_BITS-1:0] sq_dist(t_node a, t_node b);
        logic signed [COORD_BITS:0] dx, dy;
        logic [SQ_BITS-1:0] sx, sy;
        dx = a.x - b.x;
        dy = a.y - b.y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sx = dx * dx;
        sy = dy * dy;
        return {1'b0, sx} + {1'b0, sy};
    endfunction

    // feed one accepted node; on the final one, order and queue the tour
    task automatic tour_accept(t_in_beat b);
        t_node t;
        t_out_beat r;
        if (list_len < NODES) begin
            list_nodes[list_len] = '{id: b.node_id, x: b.node_x, y: b.node_y};
            list_len++;
        end else begin
            list_dropped = 1'b1;
        end
        if (b.is_last) begin
            for (int i = 0; i + 1 < list_len; i++)
                for (int j = i + 1; j < list_len; j++)
                    if (sq_dist(list_nodes[i], list_nodes[j]) <
                        sq_dist(list_nodes[i], list_nodes[i+1])) begin
                        t = list_nodes[i+1];
                        list_nodes[i+1] = list_nodes[j];
                        list_nodes[j] = t;
                    end
            for (int k = 0; k < list_len; k++) begin
                r.out_id   = list_nodes[k].id;
                r.out_x    = list_nodes[k].x;
                r.out_y    = list_nodes[k].y;
                r.out_last = (k + 1 == list_len);
                r.overflow = list_dropped;
                tour_q.push_back(r);
            end
            list_len = 0;
            list_dropped = 1'b0;
        end
    endtask

    // directed table: extremes, ties, single node
    t_in_beat direct_tab[N_DIRECT];
    // typed-in expectation for the single-node extreme list
    t_out_beat single_exp;

    initial begin
        direct_tab[0]  = '{16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1}; // single node
        direct_tab[1]  = '{16'h0000, 16'sh8000, 16'sh8000, 1'b0}; // far corners
        direct_tab[2]  = '{16'h0001, 16'sh7FFF, 16'sh7FFF, 1'b0};
        direct_tab[3]  = '{16'h0002, 16'sh8000, 16'sh7FFF, 1'b0};
        direct_tab[4]  = '{16'h0003, 16'sh7FFF, 16'sh8000, 1'b1};
        direct_tab[5]  = '{16'h0010, 16'sh0000, 16'sh0000, 1'b0}; // tie on distance
        direct_tab[6]  = '{16'h0011, 16'sh0003, 16'sh0004, 1'b0};
        direct_tab[7]  = '{16'h0012, 16'sh0004, 16'sh0003, 1'b0};
        direct_tab[8]  = '{16'h0013, -16'sh0005, 16'sh0000, 1'b0};
        direct_tab[9]  = '{16'h0014, 16'sh0001, 16'sh0001, 1'b1};
        direct_tab[10] = '{16'hAAAA, 16'sh5555, 16'shAAAA, 1'b0}; // duplicates
        direct_tab[11] = '{16'h5555, 16'sh5555, 16'shAAAA, 1'b0};
        direct_tab[12] = '{16'h1234, 16'sh5555, 16'shAAAA, 1'b0};
        direct_tab[13] = '{16'h4321, -16'sh0001, 16'sh0001, 1'b1};
        single_exp = '{16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0};
    end

    // result side: random stall pattern, compare against oldest expectation
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (tour_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected beat %p", o_result);
                end else begin
                    if (o_result !== tour_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: beat %0d exp %p got %p",
                                     beats_checked, tour_q[0], o_result);
                    end
                    void'(tour_q.pop_front());
                end
                beats_checked++;
                if (o_result.out_last) tours_seen++;
            end
            // stall pattern shifts between free flow, light and heavy back-pressure
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // drive one node beat; valid held until accepted, then model updated
    task automatic send_node(t_in_beat b);
        i_node  <= b;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tour_accept(b);
        nodes_sent++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random list: mostly short, a few overfilled to force drops
    task automatic send_list(int len);
        t_in_beat b;
        int burst;
        burst = 0;
        for (int k = 0; k < len; k++) begin
            b.node_id = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                b.node_x = 16'($urandom);
                b.node_y = 16'($urandom);
            end else begin
                b.node_x = $signed(16'($urandom_range(0, 40))) - 16'sd20;
                b.node_y = $signed(16'($urandom_range(0, 40))) - 16'sd20;
            end
            b.is_last = (k == len - 1);
            send_node(b);
            if (burst == 0) begin
                idle_gap();
                burst = $urandom_range(1, 8);
            end
            burst--;
        end
    endtask

    initial begin
        int len;
        mismatches = 0; beats_checked = 0; tours_seen = 0; nodes_sent = 0;
        list_len = 0; list_dropped = 1'b0; stall_mode = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_node = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; first row's tour is checked by hand too
        for (int r = 0; r < N_DIRECT; r++) begin
            send_node(direct_tab[r]);
            if (r == 0 && tour_q[0] !== single_exp) begin
                mismatches++;
                $display("ERROR: model single-node tour %p", tour_q[0]);
            end
            idle_gap();
        end
        // full store, then overflow with is_last on a dropped node
        send_list(NODES);
        send_list(NODES + 3);
        i_valid <= 1'b0;

        // hold off until the pipeline drains
        while (tour_q.size() != 0) @(posedge i_clk);

        while (nodes_sent < RAND_GOAL) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, NODES + 4)
                                              : $urandom_range(1, 10);
            send_list(len);
        end
        i_valid <= 1'b0;

        while (tour_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d nodes, checked %0d tour beats over %0d tours.",
                 nodes_sent, beats_checked, tours_seen);
        if (mismatches == 0 && tour_q.size() == 0)
            $display("PASS nearest_neighbor_tour_core");
        else
            $display("FAIL nearest_neighbor_tour_core");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL nearest_neighbor_tour_core");
        $finish;
    end

endmodule

`default_nettype wire
